// ===== sv/rsa_public_key_blob_parser_core_defines.svh =====
// Assertion macros shared by the key blob parser RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef RSA_PUBLIC_KEY_BLOB_PARSER_CORE_DEFINES_SVH
`define RSA_PUBLIC_KEY_BLOB_PARSER_CORE_DEFINES_SVH

// same-cycle implication, idle during reset
`define RPKB_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define RPKB_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rpkb_pkg.sv =====
// Types, codes and helpers for the key blob parser.
// No dependencies; imported by rpkb_regs and the top level.
`default_nettype none

package rpkb_pkg;

  localparam int unsigned PADDR_W = 4;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ENCODING = 2'd0;
  localparam logic [1:0] REG_KEY_TYPE = 2'd1;
  localparam logic [1:0] REG_EXTRA_OK = 2'd2;

  // roles
  localparam logic [3:0] ROLE_ENC    = 4'd0;
  localparam logic [3:0] ROLE_TYPE   = 4'd1;
  localparam logic [3:0] ROLE_KB_HI  = 4'd2;
  localparam logic [3:0] ROLE_KB_LO  = 4'd3;
  localparam logic [3:0] ROLE_ML_HI  = 4'd4;
  localparam logic [3:0] ROLE_ML_LO  = 4'd5;
  localparam logic [3:0] ROLE_MOD    = 4'd6;
  localparam logic [3:0] ROLE_EL_HI  = 4'd7;
  localparam logic [3:0] ROLE_EL_LO  = 4'd8;
  localparam logic [3:0] ROLE_EXP    = 4'd9;
  localparam logic [3:0] ROLE_EXTRA  = 4'd10;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR = 3'd1;
  localparam logic [2:0] ST_BAD_ENC   = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_SHORT_MOD = 3'd4;
  localparam logic [2:0] ST_SHORT_EXP = 3'd5;
  localparam logic [2:0] ST_EXTRA     = 3'd6;

  typedef enum logic [10:0] {
    PH_ENC   = 11'b000_0000_0001,
    PH_TYPE  = 11'b000_0000_0010,
    PH_KB_HI = 11'b000_0000_0100,
    PH_KB_LO = 11'b000_0000_1000,
    PH_ML_HI = 11'b000_0001_0000,
    PH_ML_LO = 11'b000_0010_0000,
    PH_MOD   = 11'b000_0100_0000,
    PH_EL_HI = 11'b000_1000_0000,
    PH_EL_LO = 11'b001_0000_0000,
    PH_EXP   = 11'b010_0000_0000,
    PH_EXTRA = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] expected_encoding;
    logic [7:0] expected_key_type;
    logic       extra_ok;
  } cfg_t;

  function automatic logic [3:0] phase_role(input phase_t ph);
    logic [3:0] r;
    case (ph)
      PH_ENC:   r = ROLE_ENC;
      PH_TYPE:  r = ROLE_TYPE;
      PH_KB_HI: r = ROLE_KB_HI;
      PH_KB_LO: r = ROLE_KB_LO;
      PH_ML_HI: r = ROLE_ML_HI;
      PH_ML_LO: r = ROLE_ML_LO;
      PH_MOD:   r = ROLE_MOD;
      PH_EL_HI: r = ROLE_EL_HI;
      PH_EL_LO: r = ROLE_EL_LO;
      PH_EXP:   r = ROLE_EXP;
      default:  r = ROLE_EXTRA;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rpkb_regs.sv =====
// APB register file for the key blob parser: encoding, key type, extra_ok.
// Depends on rpkb_pkg.
`default_nettype none

module rpkb_regs import rpkb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENCODING: cfg.expected_encoding <= pwdata[7:0];
        REG_KEY_TYPE: cfg.expected_key_type <= pwdata[7:0];
        REG_EXTRA_OK: cfg.extra_ok          <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENCODING: prdata = {24'd0, cfg.expected_encoding};
      REG_KEY_TYPE: prdata = {24'd0, cfg.expected_key_type};
      REG_EXTRA_OK: prdata = {31'd0, cfg.extra_ok};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/rsa_public_key_blob_parser_core.sv =====
// Key blob parser: one byte word in, one tagged result word out, registered.
// Throughput: one word per cycle while the result register is free or being taken;
// the phase/length update is a single pass of logic between the accepted word and the result register.
// Reset (rst, synchronous, high): phase back to the encoding byte, lengths and
// flags cleared, configuration registers to zero, no result pending. No clearing pass.
`default_nettype none
`include "rsa_public_key_blob_parser_core_defines.svh"

module rsa_public_key_blob_parser_core import rpkb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // APB configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // byte stream in
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic [7:0]         data_byte,
  input  wire logic               is_last,
  // tagged result out
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic      [3:0]         role,
  output logic      [7:0]         byte_value,
  output logic                    end_of_blob,
  output logic      [2:0]         status,
  output logic      [15:0]        key_bits,
  output logic      [15:0]        modulus_len,
  output logic      [15:0]        exponent_len
);

  cfg_t cfg;

  rpkb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Parse state. Lengths are zero until both of their bytes have been seen,
  // and everything is cleared after the last word of a blob.
  phase_t      phase,            phase_next;
  logic [15:0] bytes_left,       bytes_left_next;
  logic [15:0] key_bits_reg,     key_bits_reg_next;
  logic [15:0] modulus_len_reg,  modulus_len_reg_next;
  logic [15:0] exponent_len_reg, exponent_len_reg_next;
  logic [7:0]  high_byte_latch,  high_byte_latch_next;
  logic        encoding_bad,     encoding_bad_next;
  logic        type_bad,         type_bad_next;

  logic        accept;
  logic        exp_done;
  logic [15:0] bytes_left_dec;
  logic [15:0] len_word;
  logic [2:0]  status_calc;

  // Result register frees up as it is taken, so a word can enter every cycle while results are taken.
  assign item_ready     = ~result_valid | result_ready;
  assign accept         = item_valid & item_ready;
  assign bytes_left_dec = bytes_left - 16'd1;
  assign len_word       = {high_byte_latch, data_byte};

  always_comb begin
    phase_next            = phase;
    bytes_left_next       = bytes_left;
    key_bits_reg_next     = key_bits_reg;
    modulus_len_reg_next  = modulus_len_reg;
    exponent_len_reg_next = exponent_len_reg;
    high_byte_latch_next  = high_byte_latch;
    encoding_bad_next     = encoding_bad;
    type_bad_next         = type_bad;
    exp_done              = 1'b0;

    case (phase)
      PH_ENC: begin
        encoding_bad_next = (data_byte != cfg.expected_encoding);
        phase_next        = PH_TYPE;
      end
      PH_TYPE: begin
        type_bad_next = (data_byte != cfg.expected_key_type);
        phase_next    = PH_KB_HI;
      end
      PH_KB_HI: begin
        high_byte_latch_next = data_byte;
        phase_next           = PH_KB_LO;
      end
      PH_KB_LO: begin
        key_bits_reg_next = len_word;
        phase_next        = PH_ML_HI;
      end
      PH_ML_HI: begin
        high_byte_latch_next = data_byte;
        phase_next           = PH_ML_LO;
      end
      PH_ML_LO: begin
        modulus_len_reg_next = len_word;
        bytes_left_next      = len_word;
        // empty modulus skips straight to the exponent length
        phase_next           = (len_word == 16'd0) ? PH_EL_HI : PH_MOD;
      end
      PH_MOD: begin
        bytes_left_next = bytes_left_dec;
        phase_next      = (bytes_left_dec == 16'd0) ? PH_EL_HI : PH_MOD;
      end
      PH_EL_HI: begin
        high_byte_latch_next = data_byte;
        phase_next           = PH_EL_LO;
      end
      PH_EL_LO: begin
        exponent_len_reg_next = len_word;
        bytes_left_next       = len_word;
        exp_done              = (len_word == 16'd0);
        phase_next            = exp_done ? PH_EXTRA : PH_EXP;
      end
      PH_EXP: begin
        bytes_left_next = bytes_left_dec;
        exp_done        = (bytes_left_dec == 16'd0);
        phase_next      = exp_done ? PH_EXTRA : PH_EXP;
      end
      default: begin
        phase_next = PH_EXTRA;
      end
    endcase

    // Status in precedence order; flags and lengths as updated by this word.
    case (phase)
      PH_ENC, PH_TYPE, PH_KB_HI, PH_KB_LO, PH_ML_HI: status_calc = ST_SHORT_HDR;
      default: begin
        if (encoding_bad_next) begin
          status_calc = ST_BAD_ENC;
        end else if (type_bad_next) begin
          status_calc = ST_BAD_TYPE;
        end else if (phase == PH_ML_LO || phase == PH_MOD || phase == PH_EL_HI) begin
          // six or seven bytes land here too: exponent length missing
          status_calc = ST_SHORT_MOD;
        end else if (phase == PH_EL_LO || phase == PH_EXP) begin
          status_calc = exp_done ? ST_OK : ST_SHORT_EXP;
        end else begin
          status_calc = cfg.extra_ok ? ST_OK : ST_EXTRA;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_ENC;
      bytes_left       <= '0;
      key_bits_reg     <= '0;
      modulus_len_reg  <= '0;
      exponent_len_reg <= '0;
      high_byte_latch  <= '0;
      encoding_bad     <= 1'b0;
      type_bad         <= 1'b0;
    end else if (accept) begin
      if (is_last) begin
        // blob closed: ready for the next one
        phase            <= PH_ENC;
        bytes_left       <= '0;
        key_bits_reg     <= '0;
        modulus_len_reg  <= '0;
        exponent_len_reg <= '0;
        high_byte_latch  <= '0;
        encoding_bad     <= 1'b0;
        type_bad         <= 1'b0;
      end else begin
        phase            <= phase_next;
        bytes_left       <= bytes_left_next;
        key_bits_reg     <= key_bits_reg_next;
        modulus_len_reg  <= modulus_len_reg_next;
        exponent_len_reg <= exponent_len_reg_next;
        high_byte_latch  <= high_byte_latch_next;
        encoding_bad     <= encoding_bad_next;
        type_bad         <= type_bad_next;
      end
    end
  end

  // result register: valid is control, the payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_ready) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      role         <= phase_role(phase);
      byte_value   <= data_byte;
      end_of_blob  <= is_last;
      status       <= is_last ? status_calc : ST_OK;
      key_bits     <= is_last ? key_bits_reg_next : 16'd0;
      modulus_len  <= is_last ? modulus_len_reg_next : 16'd0;
      exponent_len <= is_last ? exponent_len_reg_next : 16'd0;
    end
  end

  // checks
  `RPKB_ASSERT_IMP(a_mod_count_live, clk, rst, phase == PH_MOD, bytes_left != 16'd0,
    "modulus phase with no bytes left")
  `RPKB_ASSERT_IMP(a_exp_count_live, clk, rst, phase == PH_EXP, bytes_left != 16'd0,
    "exponent phase with no bytes left")
  `RPKB_ASSERT_NXT(a_last_clears, clk, rst, accept && is_last,
    phase == PH_ENC && !encoding_bad && !type_bad && key_bits_reg == 16'd0,
    "blob state not cleared after last word")
  `RPKB_ASSERT_IMP(a_ok_needs_exp, clk, rst, result_valid && end_of_blob && status == ST_OK,
    role == ROLE_EL_LO || role == ROLE_EXP || role == ROLE_EXTRA,
    "ok status before exponent reached")
  `RPKB_ASSERT_IMP(a_mid_blob_quiet, clk, rst, result_valid && !end_of_blob,
    status == ST_OK && key_bits == 16'd0 && exponent_len == 16'd0,
    "status or lengths shown mid blob")

endmodule

`default_nettype wire
